// ===== hdl/csq_pkg.sv =====
// Shared types, codes and constants for the counting semaphore wait queue.
package csq_pkg;

   localparam int DEFAULT_QUEUE_DEPTH    = 16;
   localparam int DEFAULT_THREAD_ID_BITS = 8;

   localparam int COUNT_BITS  = 16;
   localparam int INIT_BITS   = COUNT_BITS - 1;
   localparam int CMD_BITS    = 2;
   localparam int STATUS_BITS = 2;

   localparam logic signed [COUNT_BITS-1:0] COUNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};

   typedef enum logic [CMD_BITS-1:0] {
      CMD_WAIT   = 2'd0,
      CMD_SIGNAL = 2'd1,
      CMD_FLUSH  = 2'd2
   } csq_cmd_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_DONE    = 2'd0,
      ST_BLOCKED = 2'd1,
      ST_REFUSED = 2'd2,
      ST_FULL    = 2'd3
   } csq_status_type;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_OUT  = 3'b100
   } csq_state_type;

   typedef struct packed {
      logic load_req;
      logic exec;
   } csq_ctrl_type;

   typedef struct packed {
      logic more;
   } csq_stat_type;

endpackage

// ===== hdl/csq_req_if.sv =====
// Request channel interface: command item with valid/ready handshake.
interface csq_req_if #(parameter int TID_BITS = csq_pkg::DEFAULT_THREAD_ID_BITS);
   logic                         valid;
   logic                         ready;
   logic [csq_pkg::CMD_BITS-1:0] cmd;
   logic [TID_BITS-1:0]          thread_id;
   logic                         may_block;

   modport source (output valid, output cmd, output thread_id, output may_block, input ready);
   modport sink   (input valid, input cmd, input thread_id, input may_block, output ready);
endinterface

// ===== hdl/csq_rsp_if.sv =====
// Response channel interface: result item with valid/ready handshake.
interface csq_rsp_if #(parameter int TID_BITS = csq_pkg::DEFAULT_THREAD_ID_BITS);
   logic                                  valid;
   logic                                  ready;
   logic [csq_pkg::STATUS_BITS-1:0]       status;
   logic signed [csq_pkg::COUNT_BITS-1:0] count_now;
   logic                                  released_valid;
   logic [TID_BITS-1:0]                   released_thread;
   logic                                  last;

   modport source (output valid, output status, output count_now, output released_valid,
                   output released_thread, output last, input ready);
   modport sink   (input valid, input status, input count_now, input released_valid,
                   input released_thread, input last, output ready);
endinterface

// ===== hdl/counting_semaphore_wait_queue.sv =====
// Counting semaphore with a FIFO queue of blocked thread IDs.
// Each request item is accepted in S_IDLE, executed in S_EXEC and presented
// in S_OUT, held there while rsp_chan.ready is low; a new item is accepted
// only after the last result of the previous one is taken. A flush gives one
// result per queued waiter, or one if none is queued, each in S_EXEC then
// S_OUT; the waiter RAM read is registered and the head pointer moves one
// slot per release. csr_we loads init_ff and the count at once; write it
// only while no item is in flight. No clearing pass is needed after reset.
module counting_semaphore_wait_queue #(
   parameter int QUEUE_DEPTH    = csq_pkg::DEFAULT_QUEUE_DEPTH,
   parameter int THREAD_ID_BITS = csq_pkg::DEFAULT_THREAD_ID_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [csq_pkg::INIT_BITS-1:0] csr_wdata,
   csq_req_if.sink                       req_chan,
   csq_rsp_if.source                     rsp_chan
);
   import csq_pkg::*;

   csq_ctrl_type ctrl;
   csq_stat_type stat;

   csq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .ctrl      (ctrl),
      .stat      (stat)
   );

   csq_dp #(
      .QUEUE_DEPTH    (QUEUE_DEPTH),
      .THREAD_ID_BITS (THREAD_ID_BITS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_wdata           (csr_wdata),
      .req_cmd             (req_chan.cmd),
      .req_thread_id       (req_chan.thread_id),
      .req_may_block       (req_chan.may_block),
      .ctrl                (ctrl),
      .stat                (stat),
      .rsp_status          (rsp_chan.status),
      .rsp_count_now       (rsp_chan.count_now),
      .rsp_released_valid  (rsp_chan.released_valid),
      .rsp_released_thread (rsp_chan.released_thread),
      .rsp_last            (rsp_chan.last)
   );
endmodule

// ===== hdl/csq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module csq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== hdl/csq_ctrl.sv =====
// Controller state machine: accept, execute, present result.
module csq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output csq_pkg::csq_ctrl_type ctrl,
   input  csq_pkg::csq_stat_type stat
);
   import csq_pkg::*;

   csq_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_ready) state_in = stat.more ? S_EXEC : S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready     = (state_ff == S_IDLE);
   assign rsp_valid     = (state_ff == S_OUT);
   assign ctrl.load_req = (state_ff == S_IDLE) && req_valid;
   assign ctrl.exec     = (state_ff == S_EXEC);
endmodule

// ===== hdl/csq_dp.sv =====
// Datapath: permit count, waiter queue pointers, waiter RAM and result registers.
module csq_dp #(
   parameter int QUEUE_DEPTH    = csq_pkg::DEFAULT_QUEUE_DEPTH,
   parameter int THREAD_ID_BITS = csq_pkg::DEFAULT_THREAD_ID_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [csq_pkg::INIT_BITS-1:0]         csr_wdata,
   input  logic [csq_pkg::CMD_BITS-1:0]          req_cmd,
   input  logic [THREAD_ID_BITS-1:0]             req_thread_id,
   input  logic                                  req_may_block,
   input  csq_pkg::csq_ctrl_type                 ctrl,
   output csq_pkg::csq_stat_type                 stat,
   output logic [csq_pkg::STATUS_BITS-1:0]       rsp_status,
   output logic signed [csq_pkg::COUNT_BITS-1:0] rsp_count_now,
   output logic                                  rsp_released_valid,
   output logic [THREAD_ID_BITS-1:0]             rsp_released_thread,
   output logic                                  rsp_last
);
   import csq_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int WW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);
   localparam logic [WW-1:0] FULL_CNT  = WW'(QUEUE_DEPTH);
   localparam logic [WW-1:0] ONE_CNT   = WW'(1);
   localparam logic signed [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

   csq_cmd_type                 cmd_ff;
   logic [THREAD_ID_BITS-1:0]   tid_ff;
   logic                        mb_ff;

   logic [INIT_BITS-1:0]        init_ff, init_in;
   logic signed [COUNT_BITS-1:0] count_ff, count_in;
   logic [AW-1:0]               head_ff, head_in;
   logic [AW-1:0]               tail_ff, tail_in;
   logic [WW-1:0]               wcnt_ff, wcnt_in;

   csq_status_type              status_ff, status_in;
   logic signed [COUNT_BITS-1:0] cnow_ff;
   logic                        relv_ff, relv_in;
   logic [THREAD_ID_BITS-1:0]   relt_ff, relt_in;
   logic                        last_ff, last_in;

   logic                        ram_we;
   logic [THREAD_ID_BITS-1:0]   ram_rdata;

   function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
      next_slot = (p == LAST_SLOT) ? '0 : p + AW'(1);
   endfunction

   csq_ram #(
      .WIDTH (THREAD_ID_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (tail_ff),
      .wr_data (tid_ff),
      .rd_addr (head_ff),
      .rd_data (ram_rdata)
   );

   always_comb begin
      init_in   = init_ff;
      count_in  = count_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      wcnt_in   = wcnt_ff;
      ram_we    = 1'b0;
      status_in = ST_DONE;
      relv_in   = 1'b0;
      relt_in   = '0;
      last_in   = 1'b1;

      if (csr_we) begin
         init_in  = csr_wdata;
         count_in = $signed({1'b0, csr_wdata});
      end

      if (ctrl.exec) begin
         case (cmd_ff)
            CMD_WAIT: begin
               if (mb_ff) begin
                  if (count_ff <= 0) begin
                     if (wcnt_ff >= FULL_CNT) begin
                        status_in = ST_FULL;
                     end else begin
                        count_in  = count_ff - COUNT_ONE;
                        ram_we    = 1'b1;
                        tail_in   = next_slot(tail_ff);
                        wcnt_in   = wcnt_ff + ONE_CNT;
                        status_in = ST_BLOCKED;
                     end
                  end else begin
                     count_in = count_ff - COUNT_ONE;
                  end
               end else if (count_ff <= 0) begin
                  status_in = ST_REFUSED;
               end else begin
                  count_in = count_ff - COUNT_ONE;
               end
            end
            CMD_SIGNAL: begin
               if (count_ff != COUNT_MAX) count_in = count_ff + COUNT_ONE;
               if (count_ff < 0 && wcnt_ff != '0) begin
                  relv_in = 1'b1;
                  relt_in = ram_rdata;
                  head_in = next_slot(head_ff);
                  wcnt_in = wcnt_ff - ONE_CNT;
               end
            end
            CMD_FLUSH: begin
               count_in = $signed({1'b0, init_ff});
               if (wcnt_ff != '0) begin
                  relv_in = 1'b1;
                  relt_in = ram_rdata;
                  wcnt_in = wcnt_ff - ONE_CNT;
                  last_in = (wcnt_ff == ONE_CNT);
                  if (wcnt_ff == ONE_CNT) begin
                     head_in = '0;
                     tail_in = '0;
                  end else begin
                     head_in = next_slot(head_ff);
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff  <= '0;
         count_ff <= '0;
         head_ff  <= '0;
         tail_ff  <= '0;
         wcnt_ff  <= '0;
      end else begin
         init_ff  <= init_in;
         count_ff <= count_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         wcnt_ff  <= wcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_req) begin
         cmd_ff <= csq_cmd_type'(req_cmd);
         tid_ff <= req_thread_id;
         mb_ff  <= req_may_block;
      end
      if (ctrl.exec) begin
         status_ff <= status_in;
         cnow_ff   <= count_in;
         relv_ff   <= relv_in;
         relt_ff   <= relt_in;
         last_ff   <= last_in;
      end
   end

   assign stat.more           = (cmd_ff == CMD_FLUSH) && (wcnt_ff != '0);
   assign rsp_status          = status_ff;
   assign rsp_count_now       = cnow_ff;
   assign rsp_released_valid  = relv_ff;
   assign rsp_released_thread = relt_ff;
   assign rsp_last            = last_ff;
endmodule

// ===== hdl/csq_checker.sv =====
// Port-level checker for the semaphore block, bound to the top level.
module csq_port_checker #(
   parameter int THREAD_ID_BITS = csq_pkg::DEFAULT_THREAD_ID_BITS
) (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic [csq_pkg::STATUS_BITS-1:0]       rsp_status,
   input logic signed [csq_pkg::COUNT_BITS-1:0] rsp_count_now,
   input logic                                  rsp_released_valid,
   input logic [THREAD_ID_BITS-1:0]             rsp_released_thread,
   input logic                                  rsp_last
);
   import csq_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_count_now) && $stable(rsp_released_valid)
         && $stable(rsp_released_thread) && $stable(rsp_last))
      else $error("result item changed while stalled");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request ready while a result is pending");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid ##1 rsp_valid)
      else $error("result not presented two cycles after accept");

   a_rel_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_released_valid |-> rsp_released_thread == '0)
      else $error("released_thread nonzero without a release");

   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_BLOCKED || rsp_status == ST_REFUSED
         || rsp_status == ST_FULL) |-> rsp_last && !rsp_released_valid)
      else $error("blocked, refused or full result must be a lone last item");
endmodule

bind counting_semaphore_wait_queue csq_port_checker #(
   .THREAD_ID_BITS (THREAD_ID_BITS)
) u_csq_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_chan.valid),
   .req_ready           (req_chan.ready),
   .rsp_valid           (rsp_chan.valid),
   .rsp_ready           (rsp_chan.ready),
   .rsp_status          (rsp_chan.status),
   .rsp_count_now       (rsp_chan.count_now),
   .rsp_released_valid  (rsp_chan.released_valid),
   .rsp_released_thread (rsp_chan.released_thread),
   .rsp_last            (rsp_chan.last)
);

// ===== tb/csq_checker.sv =====
// Checker for the counting semaphore: predicts result items from observed traffic and compares.
module csq_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [csq_pkg::INIT_BITS-1:0] csr_wdata,
   csq_req_if                            req_mon,
   csq_rsp_if                            rsp_mon,
   output int                            mismatches,
   output int                            pending,
   output int                            checked,
   output int                            releases
);
   import csq_pkg::*;

   localparam int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH;
   localparam int TID_W       = DEFAULT_THREAD_ID_BITS;
   localparam logic signed [COUNT_BITS-1:0] ONE_PERMIT = COUNT_BITS'(1);

   typedef struct packed {
      csq_status_type                status;
      logic signed [COUNT_BITS-1:0]  count_now;
      logic                          rel_valid;
      logic [TID_W-1:0]              rel_thread;
      logic                          last;
   } sem_result_type;

   logic [INIT_BITS-1:0]         init_permits;
   logic signed [COUNT_BITS-1:0] permits;
   logic [TID_W-1:0]             blocked_q[$];
   sem_result_type               expected_q[$];

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 30) begin
         $display("MISMATCH at %0t, result %0d: %s", $time, checked, what);
      end
   endtask

   task automatic push_result(input csq_status_type st, input logic rv,
                              input logic [TID_W-1:0] tid, input logic lst);
      sem_result_type r;
      r.status     = st;
      r.count_now  = permits;
      r.rel_valid  = rv;
      r.rel_thread = rv ? tid : '0;
      r.last       = lst;
      expected_q.push_back(r);
   endtask

   task automatic run_command(input logic [CMD_BITS-1:0] cmd, input logic [TID_W-1:0] tid,
                              input logic may_block);
      logic             was_neg;
      logic [TID_W-1:0] freed;
      case (cmd)
         CMD_WAIT: begin
            if (may_block && permits <= 0) begin
               if (blocked_q.size() >= QUEUE_DEPTH) begin
                  push_result(ST_FULL, 1'b0, '0, 1'b1);
               end else begin
                  permits = permits - ONE_PERMIT;
                  blocked_q.push_back(tid);
                  push_result(ST_BLOCKED, 1'b0, '0, 1'b1);
               end
            end else if (!may_block && permits <= 0) begin
               push_result(ST_REFUSED, 1'b0, '0, 1'b1);
            end else begin
               permits = permits - ONE_PERMIT;
               push_result(ST_DONE, 1'b0, '0, 1'b1);
            end
         end
         CMD_SIGNAL: begin
            was_neg = permits < 0;
            if (permits != COUNT_MAX) permits = permits + ONE_PERMIT;
            if (was_neg && blocked_q.size() > 0) begin
               freed = blocked_q.pop_front();
               push_result(ST_DONE, 1'b1, freed, 1'b1);
            end else begin
               push_result(ST_DONE, 1'b0, '0, 1'b1);
            end
         end
         CMD_FLUSH: begin
            permits = signed'({1'b0, init_permits});
            if (blocked_q.size() == 0) begin
               push_result(ST_DONE, 1'b0, '0, 1'b1);
            end
            while (blocked_q.size() > 0) begin
               freed = blocked_q.pop_front();
               push_result(ST_DONE, 1'b1, freed, blocked_q.size() == 0);
            end
         end
         default: begin
            push_result(ST_DONE, 1'b0, '0, 1'b1);
         end
      endcase
   endtask

   task automatic check_result();
      sem_result_type want;
      if (expected_q.size() == 0) begin
         report_mismatch("result item with none expected");
         return;
      end
      want = expected_q.pop_front();
      if (rsp_mon.status !== want.status)
         report_mismatch($sformatf("status %0d, expected %0d", rsp_mon.status, want.status));
      if (rsp_mon.count_now !== want.count_now)
         report_mismatch($sformatf("count_now %0d, expected %0d", rsp_mon.count_now,
                                   want.count_now));
      if (rsp_mon.released_valid !== want.rel_valid)
         report_mismatch($sformatf("released_valid %0b, expected %0b", rsp_mon.released_valid,
                                   want.rel_valid));
      if (rsp_mon.released_thread !== want.rel_thread)
         report_mismatch($sformatf("released_thread %0h, expected %0h",
                                   rsp_mon.released_thread, want.rel_thread));
      if (rsp_mon.last !== want.last)
         report_mismatch($sformatf("last %0b, expected %0b", rsp_mon.last, want.last));
      if (want.rel_valid) releases++;
      checked++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         init_permits = '0;
         permits      = '0;
         mismatches   = 0;
         checked      = 0;
         releases     = 0;
         blocked_q.delete();
         expected_q.delete();
      end else begin
         if (csr_we) begin
            init_permits = csr_wdata;
            permits      = signed'({1'b0, csr_wdata});
         end
         if (req_mon.valid && req_mon.ready)
            run_command(req_mon.cmd, req_mon.thread_id, req_mon.may_block);
         if (rsp_mon.valid && rsp_mon.ready)
            check_result();
      end
      pending <= expected_q.size();
   end

endmodule

// ===== tb/tb_counting_semaphore_wait_queue.sv =====
// Testbench top: clock, reset, stimulus and verdict for the counting semaphore.
module tb_counting_semaphore_wait_queue;
   import csq_pkg::*;

   localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 17;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 csr_we    = 1'b0;
   logic [INIT_BITS-1:0] csr_wdata = '0;
   logic                 steady    = 1'b0;
   int                   cycles    = 0;
   int                   items_sent = 0;
   int                   loads      = 0;
   int                   mismatches;
   int                   pending;
   int                   checked;
   int                   releases;

   csq_req_if req_chan ();
   csq_rsp_if rsp_chan ();

   counting_semaphore_wait_queue dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   csq_checker chk (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .mismatches (mismatches),
      .pending    (pending),
      .checked    (checked),
      .releases   (releases)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_chan.ready <= steady || ($urandom_range(99) >= 18);
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
   end

   task automatic send_item(input logic [CMD_BITS-1:0] cmd, input logic [7:0] tid,
                            input logic may_block);
      if (!steady && $urandom_range(99) < 18) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.cmd       <= cmd;
      req_chan.thread_id <= tid;
      req_chan.may_block <= may_block;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic load_init(input logic [INIT_BITS-1:0] value);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      loads++;
   endtask

   task automatic send_random();
      int          r;
      logic [7:0]  tid;
      r   = $urandom_range(99);
      tid = 8'($urandom_range(255));
      if (r < 50)
         send_item(CMD_WAIT, tid, $urandom_range(99) < 80);
      else if (r < 82)
         send_item(CMD_SIGNAL, tid, 1'($urandom_range(1)));
      else if (r < 93)
         send_item(CMD_FLUSH, tid, 1'($urandom_range(1)));
      else
         send_item(CMD_UNUSED, tid, 1'($urandom_range(1)));
   endtask

   initial begin
      logic [INIT_BITS-1:0] init_val;
      req_chan.valid     <= 1'b0;
      req_chan.cmd       <= CMD_WAIT;
      req_chan.thread_id <= '0;
      req_chan.may_block <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: refusal, acquire, unused command, empty flush
      load_init('0);
      send_item(CMD_WAIT, 8'h5A, 1'b0);
      send_item(CMD_SIGNAL, 8'hA5, 1'b1);
      send_item(CMD_WAIT, 8'h11, 1'b1);
      send_item(CMD_UNUSED, 8'hFF, 1'b1);
      send_item(CMD_FLUSH, 8'h00, 1'b0);
      // fill the wait queue, then overflow it
      for (int i = 0; i < 16; i++) begin
         send_item(CMD_WAIT, (i == 0) ? 8'h00 : (i == 15) ? 8'hFF : 8'($urandom_range(255)),
                   1'b1);
      end
      send_item(CMD_WAIT, 8'h77, 1'b1);
      send_item(CMD_SIGNAL, 8'h00, 1'b0);
      // reload with waiters still queued
      load_init(15'd1);
      send_item(CMD_SIGNAL, 8'h00, 1'b0);
      send_item(CMD_FLUSH, 8'h00, 1'b0);
      // saturation at the top of the count
      load_init('1);
      send_item(CMD_SIGNAL, 8'h3C, 1'b0);
      send_item(CMD_WAIT, 8'hC3, 1'b0);

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:       init_val = '0;
            1:       init_val = 15'd3;
            2:       init_val = INIT_BITS'($urandom_range(32767));
            3:       init_val = 15'd1;
            4:       init_val = '1;
            default: init_val = INIT_BITS'($urandom_range(6));
         endcase
         load_init(init_val);
         steady <= (p == 3);
         for (int i = 0; i < PHASE_ITEMS; i++) send_random();
      end

      drain();
      steady <= 1'b0;
      repeat (8) @(posedge clock);
      $display("Sent %0d request items over %0d init loads: refusals, blocking, queue full,",
               items_sent, loads);
      $display("saturation, flushes and reloads with waiters; %0d results checked, %0d releases.",
               checked, releases);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/csq_pkg.sv
hdl/csq_req_if.sv
hdl/csq_rsp_if.sv
hdl/csq_ram.sv
hdl/csq_ctrl.sv
hdl/csq_dp.sv
hdl/counting_semaphore_wait_queue.sv
hdl/csq_checker.sv
tb/csq_checker.sv
tb/tb_counting_semaphore_wait_queue.sv
